// File: src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, action codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int CELL_W     = 16;

    localparam logic [1:0] ACTION_PUT   = 2'd0;
    localparam logic [1:0] ACTION_CLEAR = 2'd1;
    localparam logic [1:0] ACTION_READ  = 2'd2;
    localparam logic [1:0] ACTION_NONE  = 2'd3;

    localparam logic [0:0] REG_FOREGROUND = 1'b0;
    localparam logic [0:0] REG_BACKGROUND = 1'b1;

    localparam logic [7:0] NEWLINE_CHAR  = 8'h0A;
    localparam logic [7:0] BLANK_CHAR    = 8'h20;
    localparam logic [7:0] RESET_COLOR   = 8'h0F;
    localparam logic [3:0] RESET_FG      = 4'hF;
    localparam logic [3:0] RESET_BG      = 4'h0;

    typedef struct packed {
        logic load;
        logic newline;
        logic write;
        logic clear;
        logic rd_issue;
        logic rd_capture;
        logic out_load;
    } tcw_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       is_newline;
        logic       line_full;
        logic       read_in_range;
        logic       out_free;
    } tcw_status_t;

endpackage

`default_nettype wire

// File: src/tcw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences one item at a time through decode, a cell write or read when the item needs one, and output.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t         cmd
);

    import tcw_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                unique case (status.action)
                    ACTION_PUT:
                    begin
                        cmd.newline = status.is_newline || status.line_full;
                        if (!status.is_newline)
                        begin
                            state_next = S_WRITE;
                        end
                    end
                    ACTION_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    ACTION_READ:
                    begin
                        if (status.read_in_range)
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = S_READ;
                        end
                    end
                    ACTION_NONE:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_DONE;
            end
            S_READ:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: src/tcw_datapath.sv
// ----------------------------------------------------------------------------
// Text console writer datapath
// Cursor, row rotation, per-row fill counts and colors, cell RAM and output.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tcw_pkg::tcw_cmd_t                 cmd,
    output tcw_pkg::tcw_status_t                   status,
    input  wire logic [tcw_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [0:0]                        cfg_index,
    input  wire logic [3:0]                        cfg_data,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [tcw_pkg::OUT_DATA_W-1:0]    m_tdata
);

    import tcw_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [RW:0]   ROWS_W   = (RW + 1)'(ROWS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                               input logic [RW-1:0] top);
        logic [RW:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= ROWS_W)
        begin
            sum = sum - ROWS_W;
        end
        return sum[RW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                                input logic [CW-1:0] col);
        return AW'(32'(prow) * 32'(COLUMNS) + 32'(col));
    endfunction

    logic [1:0]  item_action_reg;
    logic [7:0]  item_char_reg;
    logic [4:0]  item_row_reg;
    logic [6:0]  item_col_reg;

    logic [3:0]  fg_reg;
    logic [3:0]  bg_reg;
    logic [7:0]  color;

    logic [RW-1:0] cursor_row_reg;
    logic [RW-1:0] cursor_row_next;
    logic [CW-1:0] cursor_col_reg;
    logic [CW-1:0] cursor_col_next;
    logic [RW-1:0] top_reg;
    logic [RW-1:0] top_next;

    logic [CW-1:0] row_fill_reg  [ROWS];
    logic [CW-1:0] row_fill_next [ROWS];
    logic [7:0]    row_color_reg  [ROWS];
    logic [7:0]    row_color_next [ROWS];

    logic [RW-1:0] rd_phys_reg;
    logic [RW-1:0] rd_lrow;
    logic [RW-1:0] wr_phys;

    logic [7:0]  cell_char_reg;
    logic [7:0]  cell_color_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [CELL_W-1:0] ram_rdata;

    assign color   = {bg_reg, fg_reg};
    assign rd_lrow = RW'(item_row_reg);
    assign wr_phys = phys_row(cursor_row_reg, top_reg);

    assign status.action        = item_action_reg;
    assign status.is_newline    = (item_char_reg == NEWLINE_CHAR);
    assign status.line_full     = (32'(cursor_col_reg) == 32'(COLUMNS));
    assign status.read_in_range = (32'(item_row_reg) < 32'(ROWS))
                                  && (32'(item_col_reg) < 32'(COLUMNS));
    assign status.out_free      = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (cell_addr(wr_phys, cursor_col_reg)),
        .wdata ({color, item_char_reg}),
        .re    (cmd.rd_issue),
        .raddr (cell_addr(phys_row(rd_lrow, top_reg), CW'(item_col_reg))),
        .rdata (ram_rdata)
    );

    // Scrolling rotates the row origin; the old top row becomes the blank bottom row.
    always_comb
    begin
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        top_next        = top_reg;
        row_fill_next   = row_fill_reg;
        row_color_next  = row_color_reg;
        priority if (cmd.clear)
        begin
            cursor_row_next = '0;
            cursor_col_next = '0;
            top_next        = '0;
            for (int r = 0; r < ROWS; r++)
            begin
                row_fill_next[r]  = '0;
                row_color_next[r] = color;
            end
        end
        else if (cmd.newline)
        begin
            cursor_col_next = '0;
            if (cursor_row_reg != LAST_ROW)
            begin
                cursor_row_next = cursor_row_reg + RW'(1);
            end
            else
            begin
                top_next                = (top_reg == LAST_ROW) ? '0 : top_reg + RW'(1);
                row_fill_next[top_reg]  = '0;
                row_color_next[top_reg] = color;
            end
        end
        else if (cmd.write)
        begin
            cursor_col_next        = cursor_col_reg + CW'(1);
            row_fill_next[wr_phys] = cursor_col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            top_reg        <= '0;
            fg_reg         <= RESET_FG;
            bg_reg         <= RESET_BG;
            out_valid_reg  <= 1'b0;
            for (int r = 0; r < ROWS; r++)
            begin
                row_fill_reg[r]  <= '0;
                row_color_reg[r] <= RESET_COLOR;
            end
        end
        else
        begin
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            top_reg        <= top_next;
            row_fill_reg   <= row_fill_next;
            row_color_reg  <= row_color_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FOREGROUND: fg_reg <= cfg_data;
                    REG_BACKGROUND: bg_reg <= cfg_data;
                endcase
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_action_reg <= s_tdata[1:0];
            item_char_reg   <= s_tdata[9:2];
            item_row_reg    <= s_tdata[14:10];
            item_col_reg    <= s_tdata[21:15];
            cell_char_reg   <= '0;
            cell_color_reg  <= '0;
        end
        else if (cmd.rd_capture)
        begin
            if (32'(item_col_reg) < 32'(row_fill_reg[rd_phys_reg]))
            begin
                cell_char_reg  <= ram_rdata[7:0];
                cell_color_reg <= ram_rdata[15:8];
            end
            else
            begin
                cell_char_reg  <= BLANK_CHAR;
                cell_color_reg <= row_color_reg[rd_phys_reg];
            end
        end
        if (cmd.rd_issue)
        begin
            rd_phys_reg <= phys_row(rd_lrow, top_reg);
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {4'd0, 7'(cursor_col_reg), 5'(cursor_row_reg),
                             cell_color_reg, cell_char_reg};
        end
    end

endmodule

`default_nettype wire

// File: src/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell text screen with a cursor, color registers and cell reads.
// ----------------------------------------------------------------------------
// The block takes one item at a time. The controller walks each item through
// decode, at most one access of the cell RAM and the output register: a put
// other than a newline writes its cell, after a wrap when the line is full,
// and a read inside the screen reads one; a clear, a newline, an out-of-range
// read or an unused action has no cell access. The wrap to a new line happens
// in the decode cycle. Scrolling and clearing take constant time: rows are
// kept in a rotating order, and each row carries a fill count and a blank
// color, so cells beyond the fill count read as spaces in that color. No
// clearing pass follows reset. A result waits in the output register while
// the next item is accepted.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // action[1:0], char_code[9:2], read_row[14:10], read_col[21:15]
    input  wire logic [tcw_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // cell_char[7:0], cell_color[15:8], cursor_row[20:16], cursor_col[27:21]
    output logic      [tcw_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [0:0]                     cfg_index,
    input  wire logic [3:0]                     cfg_data
);

    import tcw_pkg::*;

    tcw_cmd_t    cmd;
    tcw_status_t status;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another item is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_tdata[20:16]) < 32'(ROWS))
        else $error("reported cursor row beyond the screen");

endmodule

`default_nettype wire
